// ===== rtl/assert_macros.svh =====
// Assertion helpers; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checked only while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/gcma_pkg.sv =====
package gcma_pkg;

    localparam int MAX_SIZE_DEF = 64;

    localparam int SIZE_W  = 7;
    localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;

    localparam int COST_W  = 32;
    localparam int TOTAL_W = 38;
    localparam int IDX_W   = 6;

    localparam logic signed [COST_W-1:0] COST_MAX = 32'sh7FFF_FFFF;

    // Output tdata: task_column, agent_row, has_agent, total_cost from bit 0 up
    localparam int RES_BITS = IDX_W + IDX_W + 1 + TOTAL_W;
    localparam int M_DATA_W = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic                      last_column;
        logic signed [TOTAL_W-1:0] total_cost;
        logic                      has_agent;
        logic [IDX_W-1:0]          agent_row;
        logic [IDX_W-1:0]          task_column;
    } t_result;

endpackage

// ===== rtl/gcma_scan.sv =====
module gcma_scan #(
    parameter int MAX_SIZE = gcma_pkg::MAX_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [gcma_pkg::COST_W-1:0]  i_cost,
    input  logic [gcma_pkg::SIZE_W-1:0]         i_size,
    input  logic                                i_out_free,
    output logic                                o_take,
    output logic                                o_res_valid,
    output gcma_pkg::t_result                   o_res
);

    `include "assert_macros.svh"

    localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int KW = (NW > gcma_pkg::SIZE_W) ? NW : gcma_pkg::SIZE_W;

    logic [MAX_SIZE-1:0]                 r_taken;
    logic [CW-1:0]                       r_row;
    logic [CW-1:0]                       r_col;
    logic signed [gcma_pkg::COST_W-1:0]  r_best_cost;
    logic [CW-1:0]                       r_best_row;
    logic                                r_found;
    logic signed [gcma_pkg::TOTAL_W-1:0] r_sum;

    logic [KW-1:0]                       size_ext;
    logic [KW-1:0]                       side;
    logic                                better;
    logic signed [gcma_pkg::COST_W-1:0]  cand_cost;
    logic [CW-1:0]                       cand_row;
    logic                                cand_found;
    logic                                col_end;
    logic                                prob_end;
    logic signed [gcma_pkg::TOTAL_W-1:0] n_sum;

    // Clamp the configured side to 1..MAX_SIZE
    always_comb begin
        size_ext = KW'(i_size);
        if (size_ext == '0) begin
            side = KW'(1);
        end else if (size_ext > KW'(MAX_SIZE)) begin
            side = KW'(MAX_SIZE);
        end else begin
            side = size_ext;
        end
    end

    always_comb begin
        better     = !r_taken[r_row] && (i_cost < r_best_cost);
        cand_cost  = better ? i_cost : r_best_cost;
        cand_row   = better ? r_row : r_best_row;
        cand_found = better || r_found;
        col_end    = !((KW'(r_row) + KW'(1)) < side);
        prob_end   = !((KW'(r_col) + KW'(1)) < side);
        n_sum      = cand_found ? (r_sum + gcma_pkg::TOTAL_W'(cand_cost)) : r_sum;
    end

    // Hold an entry that closes a column until the result slot is free
    assign o_take      = i_valid && (!col_end || i_out_free);
    assign o_res_valid = o_take && col_end;

    always_comb begin
        o_res.task_column = gcma_pkg::IDX_W'(r_col);
        o_res.agent_row   = cand_found ? gcma_pkg::IDX_W'(cand_row) : '0;
        o_res.has_agent   = cand_found;
        o_res.total_cost  = n_sum;
        o_res.last_column = prob_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken     <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_best_cost <= gcma_pkg::COST_MAX;
            r_best_row  <= '0;
            r_found     <= 1'b0;
            r_sum       <= '0;
        end else if (o_take) begin
            if (!col_end) begin
                r_row       <= r_row + CW'(1);
                r_best_cost <= cand_cost;
                r_best_row  <= cand_row;
                r_found     <= cand_found;
            end else begin
                r_row       <= '0;
                r_best_cost <= gcma_pkg::COST_MAX;
                r_best_row  <= '0;
                r_found     <= 1'b0;
                if (prob_end) begin
                    r_taken <= '0;
                    r_col   <= '0;
                    r_sum   <= '0;
                end else begin
                    if (cand_found) begin
                        r_taken[cand_row] <= 1'b1;
                    end
                    r_col <= r_col + CW'(1);
                    r_sum <= n_sum;
                end
            end
        end
    end

    `ASSERT_RST(a_no_best_means_max, i_clk, i_rst_n, (!r_found |-> (r_best_cost == gcma_pkg::COST_MAX)), "best cost set without a found row")
    `ASSERT_RST(a_mask_le_cols, i_clk, i_rst_n, ($countones(r_taken) <= int'(r_col)), "more rows taken than columns done")
    `ASSERT_RST(a_clear_after_last, i_clk, i_rst_n, ((o_res_valid && o_res.last_column) |=> ((r_taken == '0) && (r_col == '0) && (r_sum == '0))), "problem state not cleared after last column")
    `ASSERT_RST(a_hold_when_full, i_clk, i_rst_n, ((i_valid && col_end && !i_out_free) |-> !o_take), "column result taken into a full slot")
    `ASSERT_RST(a_no_agent_zero_row, i_clk, i_rst_n, ((o_res_valid && !o_res.has_agent) |-> ((o_res.agent_row == '0) && (o_res.total_cost == r_sum))), "empty column changed row or total")

endmodule

// ===== rtl/gcma_out.sv =====
module gcma_out (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  gcma_pkg::t_result              i_res,
    input  logic                           i_ready,
    output logic                           o_free,
    output logic                           o_valid,
    output logic [gcma_pkg::M_DATA_W-1:0]  o_data,
    output logic                           o_last
);

    logic              r_valid;
    gcma_pkg::t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_res.last_column;
    assign o_data  = gcma_pkg::M_DATA_W'({r_res.total_cost, r_res.has_agent,
                                          r_res.agent_row, r_res.task_column});

endmodule

// ===== rtl/greedy_column_min_assignment.sv =====
// Greedy column-minimum assignment over a streamed square cost matrix.
// A column's result is loaded into the output register when the scan takes its last entry.
// Throughput: 1 cost entry per cycle when not stalled, bound by the compare-select-accumulate step.
// Stalls only when a finished column meets a full output register.
// Reset (synchronous, active low): size 64, no row taken, counters and total zero.
module greedy_column_min_assignment #(
    parameter int MAX_SIZE = gcma_pkg::MAX_SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [gcma_pkg::SIZE_W-1:0]         i_cfg_data,   // matrix_size
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [gcma_pkg::COST_W-1:0]         i_s_tdata,    // cost
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // task_column[5:0], agent_row[11:6], has_agent[12], total_cost[50:13], zero pad
    output logic [gcma_pkg::M_DATA_W-1:0]       o_m_tdata,
    output logic                                o_m_tlast     // last_column
);

    logic [gcma_pkg::SIZE_W-1:0]        r_size;
    logic                               r_in_valid;
    logic signed [gcma_pkg::COST_W-1:0] r_in_cost;

    logic              take;
    logic              res_valid;
    logic              out_free;
    gcma_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= gcma_pkg::SIZE_RST;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    assign o_s_tready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_cost <= i_s_tdata;
        end
    end

    gcma_scan #(
        .MAX_SIZE(MAX_SIZE)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_in_valid),
        .i_cost     (r_in_cost),
        .i_size     (r_size),
        .i_out_free (out_free),
        .o_take     (take),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    gcma_out u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (res_valid),
        .i_res  (res),
        .i_ready(i_m_tready),
        .o_free (out_free),
        .o_valid(o_m_tvalid),
        .o_data (o_m_tdata),
        .o_last (o_m_tlast)
    );

endmodule
